@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. They compile to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/tcss_pkg.sv @@
// ----------------------------------------------------------------------------
// Tile column scroll streamer package
// Geometry constants, operation codes and the column command type shared by
// the front end, the command queue and the row sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcss_pkg;

	localparam int VRAM_COLUMNS    = 32;
	localparam int VISIBLE_ROWS    = 28;
	localparam int VISIBLE_COLUMNS = 28;
	localparam int TILE_PIXELS     = 8;
	localparam int RESULT_CAP      = 28;

	localparam int RUN_ROWS   = (VISIBLE_ROWS < RESULT_CAP) ? VISIBLE_ROWS : RESULT_CAP;
	localparam int ROW_BITS   = 5;
	localparam int RING_BITS  = $clog2(VRAM_COLUMNS);
	localparam int TILE_SHIFT = $clog2(TILE_PIXELS);

	localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(RUN_ROWS - 1);

	// Column offsets relative to the camera tile.
	localparam int RIGHT_LEAD = 29;
	localparam int RING_LEFT  = 30;
	localparam int LEFT_LAG   = 2;
	localparam int MAP_HEADER = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_HOLD       = 2'd0,
		OP_STEP_LEFT  = 2'd1,
		OP_STEP_RIGHT = 2'd2,
		OP_MOVE       = 2'd3
	} op_t;

	typedef struct packed {
		logic [RING_BITS-1:0] ring;
		logic [15:0]          base;
		logic signed [15:0]   camera;
	} cmd_t;

endpackage

`default_nettype wire

@@ sv/tile_column_scroll_streamer.sv @@
// ----------------------------------------------------------------------------
// Tile column scroll streamer
// Horizontal tile-map scroll: keeps the clamped camera and streams one level
// column into the ring-buffer VRAM each time the scroll crosses a tile.
// ----------------------------------------------------------------------------
// Usage:
//   The level width register is written through cfg_valid/cfg_ready with the
//   width on level_width; cfg_ready is always high. Write it only while idle.
//   One input transaction per video frame carries op and target_x; it is taken
//   at an edge with item_valid high and item_stall low.
//   A frame that crosses a tile boundary into a column inside the level yields
//   28 result transactions, one per visible row, with last set on the final one.
//   The first result passes through the front-end stage, the command queue,
//   the row sequencer and its output register; the rest follow one per cycle
//   while result_stall is low, as the row sequencer issues one row a cycle.
//   Frames without writes never stall the front end. Up to two column
//   commands wait in a queue; item_stall rises when a command finds it full.
//   A stalled result holds its payload until result_stall falls.
//   Reset clears the camera, the level width and all pending work.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_column_scroll_streamer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [7:0]                    level_width,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    op,
	input  wire logic signed [15:0]            target_x,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [tcss_pkg::RING_BITS-1:0]     vram_column,
	output logic [tcss_pkg::ROW_BITS-1:0]      vram_row,
	output logic [15:0]                        map_index,
	output logic signed [15:0]                 camera_x,
	output logic                               last
);

	logic           front_cmd_valid;
	logic           front_cmd_ready;
	tcss_pkg::cmd_t front_cmd;
	logic           back_cmd_valid;
	logic           back_cmd_ready;
	tcss_pkg::cmd_t back_cmd;
	logic [7:0]     level_width_q;
	logic           cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	tcss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_write),
		.cfg_data      (level_width),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.target_x      (target_x),
		.cmd_valid     (front_cmd_valid),
		.cmd_ready     (front_cmd_ready),
		.cmd           (front_cmd),
		.level_width_q (level_width_q)
	);

	tcss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_cmd_valid),
		.push_ready (front_cmd_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_cmd_valid),
		.pop_ready  (back_cmd_ready),
		.pop_cmd    (back_cmd)
	);

	tcss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.level_width_q (level_width_q),
		.cmd_valid     (back_cmd_valid),
		.cmd_ready     (back_cmd_ready),
		.cmd           (back_cmd),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.vram_column   (vram_column),
		.vram_row      (vram_row),
		.map_index     (map_index),
		.camera_x      (camera_x),
		.last          (last)
	);

endmodule

`default_nettype wire

@@ sv/tcss_front.sv @@
// ----------------------------------------------------------------------------
// Tile column scroll streamer front end
// Holds the level width and the camera, applies one operation per accepted
// transaction, and turns a tile boundary crossing into a column inside the level into a column command.
// ----------------------------------------------------------------------------
`default_nettype none

module tcss_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [1:0]          op,
	input  wire logic signed [15:0]  target_x,
	output logic                     cmd_valid,
	input  wire logic                cmd_ready,
	output tcss_pkg::cmd_t           cmd,
	output logic [7:0]               level_width_q
);

	logic signed [15:0] camera_q;
	logic               valid_s1;
	logic signed [15:0] camera_s1;
	logic [7:0]         prev_s1;

	logic signed [15:0] xmax;
	logic signed [15:0] xreq;
	logic signed [15:0] camera_next;
	logic               accept;

	logic [7:0]         now;
	logic [7:0]         diff_fwd;
	logic [7:0]         diff_back;
	logic               crossed;
	logic               moving_right;
	logic signed [15:0] tile;
	logic signed [15:0] col;
	logic signed [15:0] ring_full;
	logic               in_level;
	logic               need_cmd;
	logic               s1_done;

	assign xmax = signed'(16'(({8'd0, level_width_q} - 16'(tcss_pkg::VISIBLE_COLUMNS))
		* 16'(tcss_pkg::TILE_PIXELS)));

	always_comb begin
		xreq = camera_q;
		unique case (tcss_pkg::op_t'(op))
			tcss_pkg::OP_HOLD:       xreq = camera_q;
			tcss_pkg::OP_STEP_LEFT:  xreq = camera_q - 16'sd1;
			tcss_pkg::OP_STEP_RIGHT: xreq = camera_q + 16'sd1;
			tcss_pkg::OP_MOVE:       xreq = target_x;
		endcase
	end

	// A narrow level has a negative upper bound; a negative request still gives zero.
	always_comb begin
		if (tcss_pkg::op_t'(op) == tcss_pkg::OP_HOLD) begin
			camera_next = camera_q;
		end else if (xreq < 16'sd0) begin
			camera_next = 16'sd0;
		end else if (xreq > xmax) begin
			camera_next = xmax;
		end else begin
			camera_next = xreq;
		end
	end

	assign accept = item_valid && !item_stall;

	// Classification of the frame held in stage one.
	assign now          = camera_s1[7:0];
	assign diff_fwd     = now - prev_s1;
	assign diff_back    = prev_s1 - now;
	assign crossed      = (prev_s1[7:tcss_pkg::TILE_SHIFT] != now[7:tcss_pkg::TILE_SHIFT]);
	assign moving_right = (diff_fwd < diff_back);

	// Division by the tile size rounds toward zero, as for a signed quotient.
	assign tile = (camera_s1 + (camera_s1[15] ? 16'(tcss_pkg::TILE_PIXELS - 1) : 16'sd0))
		>>> tcss_pkg::TILE_SHIFT;

	assign col       = moving_right ? (tile + 16'(tcss_pkg::RIGHT_LEAD))
	                                : (tile - 16'(tcss_pkg::LEFT_LAG));
	assign ring_full = moving_right ? (tile + 16'(tcss_pkg::RIGHT_LEAD))
	                                : (tile + 16'(tcss_pkg::RING_LEFT));
	assign in_level  = !col[15] && (col < signed'({8'd0, level_width_q}));

	assign need_cmd   = crossed && in_level;
	assign cmd_valid  = valid_s1 && need_cmd;
	assign s1_done    = valid_s1 && (!need_cmd || cmd_ready);
	assign item_stall = valid_s1 && !s1_done;

	assign cmd.ring   = ring_full[tcss_pkg::RING_BITS-1:0];
	assign cmd.base   = 16'(col + 16'(tcss_pkg::MAP_HEADER));
	assign cmd.camera = camera_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_width_q <= 8'd0;
			camera_q      <= 16'sd0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				level_width_q <= cfg_data;
			end
			if (accept) begin
				camera_q <= camera_next;
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			camera_s1 <= camera_next;
			prev_s1   <= camera_q[7:0];
		end
	end

endmodule

`default_nettype wire

@@ sv/tcss_queue.sv @@
// ----------------------------------------------------------------------------
// Tile column scroll streamer command queue
// Short first-in first-out buffer of column commands between the front end
// and the row sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcss_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire tcss_pkg::cmd_t push_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output tcss_pkg::cmd_t      pop_cmd
);

	tcss_pkg::cmd_t                   entries_q [tcss_pkg::QUEUE_DEPTH];
	logic [tcss_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [tcss_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [tcss_pkg::QCNT_BITS-1:0]   count_q;
	logic                             push;
	logic                             pop;

	assign push_ready = (count_q != tcss_pkg::QCNT_BITS'(tcss_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	`ASSERT_ALWAYS(a_count_in_range, clk, arst_n,
		count_q <= tcss_pkg::QCNT_BITS'(tcss_pkg::QUEUE_DEPTH), "queue count overflow")
	`ASSERT_IMPLIES(a_pop_moves_count, clk, arst_n, pop && !push,
		##1 count_q == $past(count_q) - 1'b1, "pop did not shrink the queue")

endmodule

`default_nettype wire

@@ sv/tcss_back.sv @@
// ----------------------------------------------------------------------------
// Tile column scroll streamer row sequencer
// Takes one column command at a time and issues one VRAM write per visible
// row through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcss_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    level_width_q,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire tcss_pkg::cmd_t                cmd,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [tcss_pkg::RING_BITS-1:0]     vram_column,
	output logic [tcss_pkg::ROW_BITS-1:0]      vram_row,
	output logic [15:0]                        map_index,
	output logic signed [15:0]                 camera_x,
	output logic                               last
);

	logic                            busy_q;
	logic [tcss_pkg::ROW_BITS-1:0]   row_q;
	logic [15:0]                     idx_q;
	logic [tcss_pkg::RING_BITS-1:0]  ring_q;
	logic signed [15:0]              camera_q;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            issue;
	logic                            row_is_last;

	assign out_free    = !out_valid_q || !result_stall;
	assign issue       = busy_q && out_free;
	assign row_is_last = (row_q == tcss_pkg::ROW_LAST);
	assign cmd_ready   = !busy_q;

	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
		end else begin
			if (!busy_q && cmd_valid) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (issue) begin
				row_q <= row_q + 1'b1;
				if (row_is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The map index walks down the column one level row at a time.
	always_ff @(posedge clk) begin
		if (!busy_q && cmd_valid) begin
			idx_q    <= cmd.base;
			ring_q   <= cmd.ring;
			camera_q <= cmd.camera;
		end else if (issue) begin
			idx_q <= idx_q + {8'd0, level_width_q};
		end
		if (issue) begin
			vram_column <= ring_q;
			vram_row    <= row_q;
			map_index   <= idx_q;
			camera_x    <= camera_q;
			last        <= row_is_last;
		end
	end

	`ASSERT_ALWAYS(a_row_in_run, clk, arst_n,
		!(busy_q && (row_q > tcss_pkg::ROW_LAST)), "row counter ran past the run")
	`ASSERT_IMPLIES(a_last_on_final_row, clk, arst_n, result_valid,
		last == (vram_row == tcss_pkg::ROW_LAST), "last flag does not match the row")

endmodule

`default_nettype wire

@@ tb/sv/tb_tile_column_scroll_streamer.sv @@
// ----------------------------------------------------------------------------
// Tile column scroll streamer testbench
// Drives camera frames (hold, step, move) at several level widths and checks
// every row write against a cycle-free model of the camera clamp, the tile
// crossing direction and the ring-buffer column selection.
// ----------------------------------------------------------------------------

module tb_tile_column_scroll_streamer;

	localparam int TILE_W       = 8;
	localparam int SCREEN_COLS  = 28;
	localparam int RUN_LENGTH   = 28;
	localparam int AHEAD_COL    = 29;
	localparam int RING_BEHIND  = 30;
	localparam int BEHIND_COL   = 2;
	localparam int HEADER_BYTES = 2;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int IDLE_LIMIT    = 2000;

	typedef struct {
		logic [4:0]         column;
		logic [4:0]         row;
		logic [15:0]        index;
		logic signed [15:0] camera;
		logic               last_flag;
	} row_write_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          level_width;
	logic                item_valid;
	logic                item_stall;
	logic [1:0]          op;
	logic signed [15:0]  target_x;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [4:0]          vram_column;
	logic [4:0]          vram_row;
	logic [15:0]         map_index;
	logic signed [15:0]  camera_x;
	logic                last;

	// Model state.
	logic signed [15:0]  camera_model = '0;
	logic [7:0]          scroll_model = '0;
	logic [7:0]          width_model = '0;

	row_write_t          pending_writes[$];
	int                  mismatch_count = 0;
	int                  idle_cycles = 0;

	tile_column_scroll_streamer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.level_width  (level_width),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.target_x     (target_x),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.vram_column  (vram_column),
		.vram_row     (vram_row),
		.map_index    (map_index),
		.camera_x     (camera_x),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int camera_limit();
		return (int'(width_model) - SCREEN_COLS) * TILE_W;
	endfunction

	// A narrow level gives a negative upper bound; non-negative requests are
	// clamped down to it while negative requests go to zero.
	function automatic logic signed [15:0] clamp_camera(input int x);
		int upper;
		upper = camera_limit();
		if (x < 0)
			return '0;
		if (x > upper)
			x = upper;
		return 16'(x);
	endfunction

	function automatic void predict_column_writes(input tcss_pkg::op_t o,
			input logic signed [15:0] tx);
		logic signed [15:0] stepped;
		logic [7:0]         prev_byte;
		logic [7:0]         now_byte;
		logic [7:0]         fwd;
		logic [7:0]         back;
		int                 tile;
		int                 level_col;
		int                 ring;
		row_write_t         w;
		case (o)
			tcss_pkg::OP_STEP_LEFT: begin
				stepped = camera_model - 16'sd1;
				camera_model = clamp_camera(stepped);
			end
			tcss_pkg::OP_STEP_RIGHT: begin
				stepped = camera_model + 16'sd1;
				camera_model = clamp_camera(stepped);
			end
			tcss_pkg::OP_MOVE: camera_model = clamp_camera(tx);
			default: ;
		endcase
		prev_byte = scroll_model;
		now_byte = camera_model[7:0];
		scroll_model = now_byte;
		if (prev_byte / TILE_W == now_byte / TILE_W)
			return;
		tile = int'(camera_model) / TILE_W;
		fwd = now_byte - prev_byte;
		back = prev_byte - now_byte;
		// A tie in byte distance counts as moving left.
		if (fwd < back) begin
			ring = tile + AHEAD_COL;
			level_col = tile + AHEAD_COL;
		end else begin
			ring = tile + RING_BEHIND;
			level_col = tile - BEHIND_COL;
		end
		if (level_col < 0 || level_col > int'(width_model) - 1)
			return;
		for (int r = 0; r < RUN_LENGTH; r++) begin
			w.column = ring[4:0];
			w.row = r[4:0];
			w.index = 16'(HEADER_BYTES + r * int'(width_model) + level_col);
			w.camera = camera_model;
			w.last_flag = (r == RUN_LENGTH - 1);
			pending_writes.push_back(w);
		end
	endfunction

	function automatic void compare_field(input string name, input int want,
			input int got);
		if (want != got) begin
			$error("mismatch on %s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		row_write_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_writes.size() == 0) begin
				$error("result transaction with none expected: column %0d row %0d index %0d",
					vram_column, vram_row, map_index);
				mismatch_count++;
			end else begin
				want = pending_writes.pop_front();
				compare_field("vram_column", want.column, vram_column);
				compare_field("vram_row", want.row, vram_row);
				compare_field("map_index", want.index, map_index);
				compare_field("camera_x", want.camera, camera_x);
				compare_field("last", want.last_flag, last);
			end
		end
	end

	// Receiver stall pattern: stretches of no stall, light stall and heavy stall.
	int stall_mode = 0;
	int stall_run = 0;
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_run = $urandom_range(5, 40);
		end
		stall_run--;
		case (stall_mode)
			0: result_stall = 1'b0;
			1: result_stall = ($urandom_range(0, 3) == 0);
			default: result_stall = $urandom_range(0, 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_frame(input tcss_pkg::op_t o, input logic signed [15:0] tx);
		item_valid = 1'b1;
		op = o;
		target_x = tx;
		do @(posedge clk); while (item_stall);
		predict_column_writes(o, tx);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		// Frames that stream nothing may still be in the front end.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_level_width(input logic [7:0] w);
		wait_drained();
		cfg_valid = 1'b1;
		level_width = w;
		do @(posedge clk); while (!cfg_ready);
		width_model = w;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_narrow_levels();
		write_level_width(8'd0);
		send_frame(tcss_pkg::OP_HOLD, 16'sd0);
		send_frame(tcss_pkg::OP_MOVE, 16'sd100);
		send_frame(tcss_pkg::OP_STEP_RIGHT, 16'sd0);
		send_frame(tcss_pkg::OP_MOVE, -16'sd32768);
		send_frame(tcss_pkg::OP_MOVE, 16'sd32767);
		send_frame(tcss_pkg::OP_STEP_LEFT, -16'sd1);
		write_level_width(8'd27);
		send_frame(tcss_pkg::OP_MOVE, 16'sd5);
		send_frame(tcss_pkg::OP_HOLD, 16'sd1234);
		send_frame(tcss_pkg::OP_STEP_RIGHT, 16'sd0);
	endtask

	task automatic test_wide_level_edges();
		write_level_width(8'd255);
		// A move that lies less than half a circle back in the scroll byte resolves to the left-hand column.
		send_frame(tcss_pkg::OP_MOVE, 16'sd128);
		send_frame(tcss_pkg::OP_MOVE, 16'sd255);
		// Scroll byte wraps from 255 to 0 while moving right.
		send_frame(tcss_pkg::OP_STEP_RIGHT, 16'sd0);
		send_frame(tcss_pkg::OP_MOVE, 16'sd32767);
		send_frame(tcss_pkg::OP_STEP_LEFT, 16'sd0);
		send_frame(tcss_pkg::OP_STEP_RIGHT, 16'sd0);
		send_frame(tcss_pkg::OP_MOVE, 16'sd0);
		send_frame(tcss_pkg::OP_MOVE, 16'sd7);
		send_frame(tcss_pkg::OP_STEP_RIGHT, 16'sd0);
	endtask

	task automatic test_exact_fit_level();
		write_level_width(8'd28);
		send_frame(tcss_pkg::OP_MOVE, 16'sd1000);
		send_frame(tcss_pkg::OP_STEP_RIGHT, 16'sd0);
	endtask

	// Mostly runs of steps in one direction, with moves, holds and reversals.
	task automatic test_random_scrolling(input logic [7:0] w, input int count);
		int   burst_left;
		int   pick;
		int   upper;
		int   span;
		bit   heading_right;
		tcss_pkg::op_t o;
		logic signed [15:0] tx;
		write_level_width(w);
		burst_left = 0;
		heading_right = 1'b1;
		for (int k = 0; k < count; k++) begin
			if (burst_left == 0) begin
				item_valid = 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			upper = camera_limit();
			if (heading_right && camera_model >= upper)
				heading_right = 1'b0;
			else if (!heading_right && camera_model <= 0)
				heading_right = 1'b1;
			else if ($urandom_range(0, 9) == 0)
				heading_right = !heading_right;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				o = tcss_pkg::OP_HOLD;
			else if (pick < 20)
				o = tcss_pkg::OP_MOVE;
			else if (pick < 30)
				o = heading_right ? tcss_pkg::OP_STEP_LEFT : tcss_pkg::OP_STEP_RIGHT;
			else
				o = heading_right ? tcss_pkg::OP_STEP_RIGHT : tcss_pkg::OP_STEP_LEFT;
			span = (upper > 0 ? upper : 0) + 16;
			case ($urandom_range(0, 9))
				0, 1: tx = 16'($urandom_range(0, 65535));
				2, 3, 4: tx = 16'($urandom_range(0, span));
				default: tx = 16'(int'(camera_model) + int'($urandom_range(0, 40)) - 20);
			endcase
			send_frame(o, tx);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		level_width = '0;
		item_valid = 1'b0;
		op = tcss_pkg::OP_HOLD;
		target_x = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_narrow_levels();
		test_wide_level_edges();
		test_exact_fit_level();
		test_random_scrolling(8'd255, 55);
		test_random_scrolling(8'($urandom_range(29, 100)), 50);
		test_random_scrolling(8'($urandom_range(0, 29)), 25);
		test_random_scrolling(8'($urandom_range(60, 254)), 50);

		item_valid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
